>>> hw/rtl/centered_window_track_smoother_defines.svh
// assertion macros shared by the smoother rtl
// depends on nothing; define ASSERT_OFF to drop all checks
`ifndef CENTERED_WINDOW_TRACK_SMOOTHER_DEFINES_SVH
`define CENTERED_WINDOW_TRACK_SMOOTHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CWTS_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CWTS_ASSERT_NEXT(label, clock, reset, pre, post, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error(msg);
`else
`define CWTS_ASSERT(label, clock, reset, prop, msg)
`define CWTS_ASSERT_NEXT(label, clock, reset, pre, post, msg)
`endif
`endif

>>> hw/rtl/cwts_pkg.sv
// shared types and constants for the centered window track smoother
// used by controller, datapath and top level
`timescale 1ns / 1ps
package cwts_pkg;
  localparam int HALF_WIDTH = 5;
  localparam int CNT_WIDTH = 6;
  localparam int PCOUNT_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SMOOTHING_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIT_ERROR_LIMIT = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_SETUP, S_READ, S_DRAIN, S_DIVINIT, S_DIV, S_OUT, S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_first;
    logic load_flush;
    logic setup;
    logic read;
    logic div_init;
    logic div_step;
    logic out_load;
    logic next_d;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic first_emit;
    logic flush_nonempty;
    logic flush_mode;
    logic more_flush;
    logic read_last;
    logic div_done;
    logic out_free;
  } status_t;
endpackage

>>> hw/rtl/cwts_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module cwts_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hw/rtl/cwts_ctrl.sv
// sequencing state machine for the smoother
// depends on cwts_pkg
`timescale 1ns / 1ps
module cwts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cwts_pkg::status_t st,
  output cwts_pkg::cmd_t    cmd
);
  cwts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cwts_pkg::S_IDLE: begin
        if (in_valid) state_next = cwts_pkg::S_FIRST;
      end
      cwts_pkg::S_FIRST: begin
        if (st.first_emit || st.flush_nonempty) state_next = cwts_pkg::S_SETUP;
        else state_next = cwts_pkg::S_DONE;
      end
      cwts_pkg::S_SETUP: state_next = cwts_pkg::S_READ;
      cwts_pkg::S_READ: begin
        if (st.read_last) state_next = cwts_pkg::S_DRAIN;
      end
      cwts_pkg::S_DRAIN: state_next = cwts_pkg::S_DIVINIT;
      cwts_pkg::S_DIVINIT: state_next = cwts_pkg::S_DIV;
      cwts_pkg::S_DIV: begin
        if (st.div_done) state_next = cwts_pkg::S_OUT;
      end
      cwts_pkg::S_OUT: begin
        if (st.out_free) begin
          if (st.more_flush || (!st.flush_mode && st.flush_nonempty)) begin
            state_next = cwts_pkg::S_SETUP;
          end else begin
            state_next = cwts_pkg::S_DONE;
          end
        end
      end
      cwts_pkg::S_DONE: state_next = cwts_pkg::S_IDLE;
      default: state_next = cwts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      cwts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      cwts_pkg::S_FIRST: begin
        if (st.first_emit) cmd.load_first = 1'b1;
        else if (st.flush_nonempty) cmd.load_flush = 1'b1;
      end
      cwts_pkg::S_SETUP: cmd.setup = 1'b1;
      cwts_pkg::S_READ: cmd.read = 1'b1;
      cwts_pkg::S_DRAIN: ;
      cwts_pkg::S_DIVINIT: cmd.div_init = 1'b1;
      cwts_pkg::S_DIV: cmd.div_step = !st.div_done;
      cwts_pkg::S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.more_flush) cmd.next_d = 1'b1;
          else if (!st.flush_mode && st.flush_nonempty) cmd.load_flush = 1'b1;
        end
      end
      cwts_pkg::S_DONE: cmd.finish = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> hw/rtl/cwts_datapath.sv
// ring storage, window sum, iterative divider and output register
// depends on cwts_pkg, cwts_ram and the assertion macro header
`timescale 1ns / 1ps
`include "centered_window_track_smoother_defines.svh"
module cwts_datapath #(
  parameter int RING_DEPTH = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cwts_pkg::cmd_t                        cmd,
  output cwts_pkg::status_t                     st,
  input  logic [cwts_pkg::HALF_WIDTH-1:0]       half,
  input  logic [31:0]                           limit,
  input  logic signed [VALUE_WIDTH-1:0]         in_value,
  input  logic [TIME_WIDTH-1:0]                 in_time,
  input  logic                                  in_present,
  input  logic [31:0]                           in_fit_error,
  input  logic                                  in_run_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [VALUE_WIDTH-1:0]         out_value,
  output logic [TIME_WIDTH-1:0]                 out_time,
  output logic                                  out_warning,
  output logic                                  out_last
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int HW = cwts_pkg::HALF_WIDTH;
  localparam int CW = cwts_pkg::CNT_WIDTH;
  localparam int PW = cwts_pkg::PCOUNT_WIDTH;
  localparam int SUMW = VALUE_WIDTH + CW;
  localparam int DCW = $clog2(SUMW + 1);
  localparam int RW = VALUE_WIDTH + TIME_WIDTH;

  logic [AW-1:0] wp;
  logic [PW-1:0] count;
  logic warn, item_present, item_ending, flush_mode;
  logic [HW-1:0] d;
  logic [AW-1:0] k, k_end;
  logic [CW-1:0] cnt;
  logic signed [SUMW-1:0] sum;
  logic rd_pend, rd_center;
  logic [TIME_WIDTH-1:0] time_hold;
  logic [CW-1:0] rem;
  logic [SUMW-1:0] dq;
  logic neg;
  logic [DCW-1:0] div_left;

  logic [RW-1:0] rdata;
  logic [AW:0] slot_sum;
  logic [AW-1:0] slot;
  logic [HW-1:0] m, back;
  logic [PW-1:0] avail;
  logic [CW:0] rem_sh;
  logic [SUMW-1:0] mag;

  always_comb begin
    slot_sum = (AW+1)'(wp) + (AW+1)'(RING_DEPTH - 1) - (AW+1)'(k);
    if (slot_sum >= (AW+1)'(RING_DEPTH)) slot_sum = slot_sum - (AW+1)'(RING_DEPTH);
    slot = slot_sum[AW-1:0];
    m = (count < PW'(half)) ? count[HW-1:0] : half;
    avail = count - PW'(1) - PW'(d);
    back = (avail < PW'(half)) ? avail[HW-1:0] : half;
    rem_sh = {rem, dq[SUMW-1]};
    mag = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  end

  cwts_ram #(.WIDTH(RW), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.accept && in_present),
    .waddr (wp),
    .wdata ({in_time, in_value}),
    .re    (cmd.read),
    .raddr (slot),
    .rdata (rdata)
  );

  always_comb begin
    st.first_emit = item_present && (count > PW'(half));
    st.flush_nonempty = item_ending && (m != '0);
    st.flush_mode = flush_mode;
    st.more_flush = flush_mode && (d != '0);
    st.read_last = (k == k_end);
    st.div_done = (div_left == '0);
    st.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      count <= '0;
      warn <= 1'b0;
      item_present <= 1'b0;
      item_ending <= 1'b0;
      flush_mode <= 1'b0;
      rd_pend <= 1'b0;
      div_left <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.read;
      if (cmd.accept) begin
        item_present <= in_present;
        item_ending <= in_run_end;
        if (in_present) begin
          wp <= (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + AW'(1);
          if (count != '1) count <= count + PW'(1);
          if (in_fit_error >= limit) warn <= 1'b1;
        end
      end
      if (cmd.load_first) flush_mode <= 1'b0;
      if (cmd.load_flush) flush_mode <= 1'b1;
      if (cmd.div_init) div_left <= DCW'(SUMW);
      if (cmd.div_step) div_left <= div_left - DCW'(1);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.finish && item_ending) begin
        count <= '0;
        wp <= '0;
        warn <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) d <= half;
    if (cmd.load_flush) d <= m - HW'(1);
    if (cmd.next_d) d <= d - HW'(1);
    if (cmd.setup) begin
      k <= '0;
      k_end <= AW'(CW'(d) + CW'(back));
      cnt <= CW'(d) + CW'(back) + CW'(1);
    end
    if (cmd.read) begin
      k <= k + AW'(1);
      rd_center <= (k == AW'(d));
    end
    if (cmd.setup || (cmd.finish && item_ending)) begin
      sum <= '0;
    end else if (rd_pend) begin
      sum <= sum + SUMW'(signed'(rdata[VALUE_WIDTH-1:0]));
    end
    if (rd_pend && rd_center) time_hold <= rdata[RW-1:VALUE_WIDTH];
    if (cmd.div_init) begin
      neg <= sum[SUMW-1];
      dq <= mag;
      rem <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, cnt}) begin
        rem <= CW'(rem_sh - {1'b0, cnt});
        dq <= {dq[SUMW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CW-1:0];
        dq <= {dq[SUMW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_value <= VALUE_WIDTH'(neg ? SUMW'(-dq) : dq);
      out_time <= time_hold;
      out_warning <= warn;
      out_last <= flush_mode ? (d == '0) : (item_ending && (m == '0));
    end
  end

  `CWTS_ASSERT(a_load_free, clk, rst, cmd.out_load |-> (!out_valid || out_ready), "result overwritten")
  `CWTS_ASSERT(a_read_range, clk, rst, cmd.read |-> (k <= k_end), "window read past its end")
  `CWTS_ASSERT(a_accept_quiet, clk, rst, cmd.accept |-> !rd_pend, "item taken with a read in flight")
  `CWTS_ASSERT_NEXT(a_div_len, clk, rst, cmd.div_init, div_left == DCW'(SUMW), "divider not armed")
endmodule

>>> hw/rtl/centered_window_track_smoother.sv
// Centered moving-average smoother for one track curve. Each present sample goes
// into a ring; each result is the truncated mean of up to 2*half+1 neighbors, read
// one ring entry per cycle and divided by a bit-serial restoring divider of
// VALUE_WIDTH+6 steps. An item that ends a run adds one result per pending center.
// Items are taken only between items; a finished result waits in the output
// register meanwhile.
// Depends on cwts_pkg, cwts_ctrl, cwts_datapath.
`timescale 1ns / 1ps
module centered_window_track_smoother #(
  parameter int RING_DEPTH = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cwts_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [31:0]                             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [VALUE_WIDTH-1:0]           sample_value,
  input  logic [TIME_WIDTH-1:0]                   frame_time,
  input  logic                                    sample_present,
  input  logic [31:0]                             fit_error,
  input  logic                                    run_end,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [VALUE_WIDTH-1:0]           smoothed_value,
  output logic [TIME_WIDTH-1:0]                   smoothed_time,
  output logic                                    fit_warning,
  output logic                                    last_result
);
  localparam int MAX_HALF = (RING_DEPTH - 1) / 2;
  localparam int HW = cwts_pkg::HALF_WIDTH;

  logic [5:0] smoothing_window;
  logic [31:0] fit_error_limit;
  logic [HW-1:0] half;
  cwts_pkg::cmd_t cmd;
  cwts_pkg::status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_window <= '0;
      fit_error_limit <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cwts_pkg::CFG_SMOOTHING_WINDOW: smoothing_window <= cfg_data[5:0];
        cwts_pkg::CFG_FIT_ERROR_LIMIT: fit_error_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign half = (32'(smoothing_window[5:1]) > MAX_HALF) ? HW'(MAX_HALF)
                                                         : smoothing_window[5:1];

  cwts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  cwts_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .half         (half),
    .limit        (fit_error_limit),
    .in_value     (sample_value),
    .in_time      (frame_time),
    .in_present   (sample_present),
    .in_fit_error (fit_error),
    .in_run_end   (run_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (smoothed_value),
    .out_time     (smoothed_time),
    .out_warning  (fit_warning),
    .out_last     (last_result)
  );
endmodule

>>> verif/centered_window_track_smoother_checker.sv
// predicts and checks the smoothed results of centered_window_track_smoother
// watches the config, input and output channels; depends on cwts_pkg
`timescale 1ns / 1ps
module centered_window_track_smoother_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [cwts_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [31:0]                   sample_value,
  input  logic [19:0]                          frame_time,
  input  logic                                 sample_present,
  input  logic [31:0]                          fit_error,
  input  logic                                 run_end,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [31:0]                   smoothed_value,
  input  logic [19:0]                          smoothed_time,
  input  logic                                 fit_warning,
  input  logic                                 last_result,
  output int                                   errors,
  output int                                   pending
);
  localparam int DEPTH = 64;
  localparam int MAX_HALF = (DEPTH - 1) / 2;

  typedef struct packed {
    logic signed [31:0] value;
    logic [19:0]        frame;
    logic               warn;
    logic               last;
  } smooth_t;

  logic [5:0]         window_len;
  logic [31:0]        err_limit;
  logic signed [31:0] value_hist [DEPTH];
  logic [19:0]        time_hist [DEPTH];
  int                 sample_count;
  int                 wr_slot;
  logic               warn_flag;
  smooth_t            expected_means[$];

  assign pending = expected_means.size();

  function automatic smooth_t window_mean(int d, int h);
    smooth_t r;
    int fwd, avail, back;
    longint sum;
    fwd = d < h ? d : h;
    avail = sample_count - 1 - d;
    back = avail < h ? avail : h;
    sum = 0;
    for (int k = d - fwd; k <= d + back; k++)
      sum += longint'(value_hist[(wr_slot + DEPTH - 1 - k) % DEPTH]);
    r.value = 32'(sum / longint'(fwd + back + 1));
    r.frame = time_hist[(wr_slot + DEPTH - 1 - d) % DEPTH];
    r.warn = warn_flag;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_means();
    int h, m, n;
    smooth_t r;
    h = window_len / 2;
    if (h > MAX_HALF) h = MAX_HALF;
    n = 0;
    if (sample_present) begin
      value_hist[wr_slot] = sample_value;
      time_hist[wr_slot] = frame_time;
      wr_slot = (wr_slot + 1) % DEPTH;
      if (sample_count < 65535) sample_count++;
      if (fit_error >= err_limit) warn_flag = 1'b1;
      if (sample_count > h) begin
        expected_means = {expected_means, window_mean(h, h)};
        n++;
      end
    end
    if (run_end) begin
      m = sample_count < h ? sample_count : h;
      while (m > 0) begin
        m--;
        expected_means = {expected_means, window_mean(m, h)};
        n++;
      end
      if (n > 0) begin
        r = expected_means.pop_back();
        r.last = 1'b1;
        expected_means = {expected_means, r};
      end
      sample_count = 0;
      wr_slot = 0;
      warn_flag = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    smooth_t e;
    if (rst) begin
      window_len = '0;
      err_limit = '1;
      sample_count = 0;
      wr_slot = 0;
      warn_flag = 1'b0;
      errors = 0;
      expected_means.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cwts_pkg::CFG_SMOOTHING_WINDOW) window_len = cfg_data[5:0];
        else if (cfg_index == cwts_pkg::CFG_FIT_ERROR_LIMIT) err_limit = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected item value %h time %h warn %b last %b", $time,
                   smoothed_value, smoothed_time, fit_warning, last_result);
          errors++;
        end else begin
          e = expected_means.pop_front();
          if (smoothed_value !== e.value) begin
            $display("%0t: smoothed_value expected %h actual %h", $time, e.value,
                     smoothed_value);
            errors++;
          end
          if (smoothed_time !== e.frame) begin
            $display("%0t: smoothed_time expected %h actual %h", $time, e.frame,
                     smoothed_time);
            errors++;
          end
          if (fit_warning !== e.warn) begin
            $display("%0t: fit_warning expected %b actual %b", $time, e.warn, fit_warning);
            errors++;
          end
          if (last_result !== e.last) begin
            $display("%0t: last_result expected %b actual %b", $time, e.last, last_result);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) predict_means();
    end
  end
endmodule

>>> verif/centered_window_track_smoother_tb.sv
// stimulus and verdict for centered_window_track_smoother
// depends on cwts_pkg, the smoother rtl and centered_window_track_smoother_checker
`timescale 1ns / 1ps
module centered_window_track_smoother_tb;
  localparam logic [cwts_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 220;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [cwts_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_ready;
  logic signed [31:0] sample_value;
  logic [19:0] frame_time;
  logic        sample_present, run_end;
  logic [31:0] fit_error;
  logic        out_valid, out_ready;
  logic signed [31:0] smoothed_value;
  logic [19:0] smoothed_time;
  logic        fit_warning, last_result;
  int          errors, pending, cycles, sent;
  logic        steady;

  centered_window_track_smoother dut (.*);

  centered_window_track_smoother_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic idle_now();
    return !steady && ($urandom_range(99) < 6);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= !idle_now();
    if (cycles >= CYCLE_LIMIT) begin
      $display("centered_window_track_smoother regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [cwts_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    repeat (16) @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(logic [31:0] v, logic [19:0] t, logic p, logic [31:0] fe,
                             logic e);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    frame_time <= t;
    sample_present <= p;
    fit_error <= fe;
    run_end <= e;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic random_run(int len, logic [31:0] lim);
    logic [31:0] v;
    logic [19:0] t;
    t = 20'($urandom);
    for (int i = 0; i < len; i++) begin
      v = $urandom_range(3) == 0 ? $urandom_range(255) - 128 : $urandom;
      t = t + 20'($urandom_range(1, 4));
      send_sample(v, ($urandom_range(9) == 0) ? 20'($urandom) : t,
                  $urandom_range(99) < 88,
                  ($urandom_range(9) == 0) ? lim + $urandom_range(3) : $urandom,
                  i == len - 1);
    end
  endtask

  initial begin
    int w;
    logic [31:0] lim;
    sent = 0;
    steady = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_value = '0;
    frame_time = '0;
    sample_present = 1'b0;
    fit_error = '0;
    run_end = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through with reset registers, extremes of every field
    send_sample(32'h7fffffff, 20'h00000, 1'b1, 32'h00000000, 1'b0);
    send_sample(32'h80000000, 20'hfffff, 1'b1, 32'hffffffff, 1'b0);
    send_sample(32'hffffffff, 20'h12345, 1'b0, 32'hffffffff, 1'b0);
    send_sample(32'h00000000, 20'h00001, 1'b1, 32'h00010000, 1'b1);
    // empty run, then a dropped closing item
    send_sample(32'h00000001, 20'h00002, 1'b0, 32'h0, 1'b1);
    send_sample(32'h00000005, 20'h00003, 1'b1, 32'h0, 1'b0);
    send_sample(32'h00000007, 20'h00004, 1'b0, 32'h0, 1'b1);

    write_reg(cwts_pkg::CFG_SMOOTHING_WINDOW, 32'd5);
    write_reg(cwts_pkg::CFG_FIT_ERROR_LIMIT, 32'h00008000);
    write_reg(CFG_UNUSED, 32'hffffffff);
    send_sample(32'h7fffffff, 20'd10, 1'b1, 32'h00007fff, 1'b0);
    send_sample(32'h7fffffff, 20'd11, 1'b1, 32'h00000000, 1'b0);
    send_sample(32'h80000000, 20'd12, 1'b0, 32'hffffffff, 1'b0);
    send_sample(32'hfffffffd, 20'd13, 1'b1, 32'h00008000, 1'b0);
    send_sample(32'h00000003, 20'd14, 1'b1, 32'h0, 1'b0);
    send_sample(32'h80000000, 20'd15, 1'b1, 32'h0, 1'b0);
    send_sample(32'h00000004, 20'd16, 1'b0, 32'h0, 1'b1);
    // run shorter than the half window
    send_sample(32'hfffffff9, 20'd20, 1'b1, 32'h0, 1'b1);

    write_reg(cwts_pkg::CFG_SMOOTHING_WINDOW, 32'd63);
    write_reg(cwts_pkg::CFG_FIT_ERROR_LIMIT, 32'h0);
    random_run(40, 32'h0);

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(4))
        0: w = 0;
        1: w = 1;
        2: w = 63;
        3: w = $urandom_range(2, 8);
        default: w = $urandom_range(63);
      endcase
      lim = $urandom_range(1) ? $urandom : 32'hffffffff;
      write_reg(cwts_pkg::CFG_SMOOTHING_WINDOW, 32'(w));
      write_reg(cwts_pkg::CFG_FIT_ERROR_LIMIT, lim);
      steady = (sent > 100 && sent < 160);
      random_run($urandom_range(1, w > 40 ? 40 : 20), lim);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("centered_window_track_smoother regression: pass");
    else
      $display("centered_window_track_smoother regression: fail");
    $finish;
  end
endmodule
